/* design/fwc_pkg.sv */
// ----------------------------------------------------------------------------
// fwc_pkg
// Shared types, sizes and replacement tables for the four-way cache tag block.
// ----------------------------------------------------------------------------
package fwc_pkg;

    localparam int NUM_SETS   = 32;
    localparam int NUM_WAYS   = 4;
    localparam int SET_BITS   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ADDR_W     = 30;
    localparam int TAG_W      = 22;
    localparam int TAG_LSB    = 8;
    localparam int LINE_BITS  = 3;
    localparam int QUOT_W     = ADDR_W - LINE_BITS;
    localparam int CNT_W      = 32;

    localparam bit SETS_POW2  = ((NUM_SETS & (NUM_SETS - 1)) == 0);

    // set index remainder unit, used when the set count is not a power of two
    localparam int MOD_STEP   = 7;
    localparam int MOD_CYCLES = (QUOT_W + MOD_STEP - 1) / MOD_STEP;
    localparam int MOD_W      = MOD_CYCLES * MOD_STEP;
    localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;
    localparam logic [SET_BITS:0] SETS_WIDE = (SET_BITS + 1)'(NUM_SETS);

    localparam logic [1:0] VICTIM_OF_STATE [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    localparam logic [2:0] PLRU_NEXT [8][4] = '{
        '{3'd6, 3'd4, 3'd1, 3'd0},
        '{3'd7, 3'd5, 3'd1, 3'd0},
        '{3'd6, 3'd4, 3'd3, 3'd2},
        '{3'd7, 3'd5, 3'd3, 3'd2},
        '{3'd6, 3'd4, 3'd1, 3'd0},
        '{3'd7, 3'd5, 3'd1, 3'd0},
        '{3'd6, 3'd4, 3'd3, 3'd2},
        '{3'd7, 3'd5, 3'd3, 3'd2}
    };

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [TAG_W-1:0]  tag;
    } t_way_entry;

    typedef struct packed {
        t_way_entry [NUM_WAYS-1:0] ways;
        logic [2:0]                plru;
    } t_set_row;

    localparam int ROW_W = $bits(t_set_row);

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic              operation;
    } t_item;

    typedef struct packed {
        logic             hit;
        logic [1:0]       way;
        logic             write_back;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] write_back_total;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [1:0] way;
        logic       write_back;
    } t_lookup;

endpackage

/* design/four_way_cache_tag_plru_top.sv */
// ----------------------------------------------------------------------------
// four_way_cache_tag_plru_top
// Tag side of a 4-way set-associative write-back cache with tree PLRU.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. Each set is one row
// of a synchronous RAM (tags, valid and dirty bits of four ways plus the PLRU
// state); the row is read, updated and written back, and the result appears
// on o_result with o_valid high for exactly one cycle, which the receiver
// must take. With a power-of-two set count an access goes through a RAM
// read, then lookup and write back; busy falls as the result is shown, so
// only one access is in flight at a time. Other set counts first run the
// set index remainder unit. After reset the RAM is cleared one row per
// cycle, all NUM_SETS rows, with busy held high.
// ----------------------------------------------------------------------------
module four_way_cache_tag_plru_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  fwc_pkg::t_item     i_item,
    output logic               busy,
    output logic               o_valid,
    output fwc_pkg::t_result   o_result
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MOD   = 2'd2;
    localparam logic [1:0] S_LOOK  = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [fwc_pkg::SET_BITS-1:0]   r_clr_idx;
    logic [fwc_pkg::SET_BITS-1:0]   r_set;
    logic [fwc_pkg::TAG_W-1:0]      r_tag;
    logic                           r_write;
    logic [fwc_pkg::CNT_W-1:0]      r_hit_cnt;
    logic [fwc_pkg::CNT_W-1:0]      r_miss_cnt;
    logic [fwc_pkg::CNT_W-1:0]      r_wb_cnt;
    logic [fwc_pkg::CNT_W-1:0]      n_hit_cnt;
    logic [fwc_pkg::CNT_W-1:0]      n_miss_cnt;
    logic [fwc_pkg::CNT_W-1:0]      n_wb_cnt;
    logic                           r_valid;
    fwc_pkg::t_result               r_result;

    logic                           w_accept;
    logic                           w_set_done;
    logic [fwc_pkg::SET_BITS-1:0]   w_set;
    logic                           w_we;
    logic [fwc_pkg::SET_BITS-1:0]   w_waddr;
    logic [fwc_pkg::ROW_W-1:0]      w_wdata;
    logic [fwc_pkg::ROW_W-1:0]      w_rdata;
    fwc_pkg::t_set_row              w_new_row;
    fwc_pkg::t_lookup               w_look;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    fwc_set_index u_set_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_quot  (i_item.word_address[fwc_pkg::ADDR_W-1:fwc_pkg::LINE_BITS]),
        .o_done  (w_set_done),
        .o_set   (w_set)
    );

    fwc_ram #(
        .WIDTH (fwc_pkg::ROW_W),
        .DEPTH (fwc_pkg::NUM_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_set),
        .o_rdata (w_rdata)
    );

    fwc_lookup u_lookup (
        .i_row   (fwc_pkg::t_set_row'(w_rdata)),
        .i_tag   (r_tag),
        .i_write (r_write),
        .o_look  (w_look),
        .o_row   (w_new_row)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_set;
        w_wdata = w_new_row;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else if (r_state == S_LOOK) begin
            w_we    = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == fwc_pkg::SET_BITS'(fwc_pkg::NUM_SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_set_done ? S_LOOK : S_MOD;
                end
            end
            S_MOD: begin
                if (w_set_done) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign n_hit_cnt  = r_hit_cnt + fwc_pkg::CNT_W'(w_look.hit);
    assign n_miss_cnt = r_miss_cnt + fwc_pkg::CNT_W'(!w_look.hit);
    assign n_wb_cnt   = r_wb_cnt + fwc_pkg::CNT_W'(w_look.write_back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_wb_cnt   <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_LOOK);
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_LOOK) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
                r_wb_cnt   <= n_wb_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag   <= i_item.word_address[fwc_pkg::ADDR_W-1:fwc_pkg::TAG_LSB];
            r_write <= i_item.operation;
        end
        if (w_set_done) begin
            r_set <= w_set;
        end
        if (r_state == S_LOOK) begin
            r_result.hit              <= w_look.hit;
            r_result.way              <= w_look.way;
            r_result.write_back       <= w_look.write_back;
            r_result.hit_total        <= n_hit_cnt;
            r_result.miss_total       <= n_miss_cnt;
            r_result.write_back_total <= n_wb_cnt;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/fwc_ram.sv */
// ----------------------------------------------------------------------------
// fwc_ram
// Simple dual-port synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/fwc_set_index.sv */
// ----------------------------------------------------------------------------
// fwc_set_index
// Set index from the line address: a bit select for power-of-two set counts,
// otherwise a multi-cycle remainder unit working several bits per cycle.
// ----------------------------------------------------------------------------
module fwc_set_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fwc_pkg::QUOT_W-1:0]    i_quot,
    output logic                          o_done,
    output logic [fwc_pkg::SET_BITS-1:0]  o_set
);

    generate
        if (fwc_pkg::SETS_POW2) begin : g_pow2
            assign o_done = i_start;
            assign o_set  = i_quot[fwc_pkg::SET_BITS-1:0];
        end else begin : g_rem
            logic                           r_run;
            logic [fwc_pkg::MOD_CNT_W-1:0]  r_cnt;
            logic [fwc_pkg::MOD_W-1:0]      r_val;
            logic [fwc_pkg::SET_BITS-1:0]   r_rem;
            logic [fwc_pkg::SET_BITS-1:0]   n_rem;
            logic                           w_last;

            always_comb begin
                logic [fwc_pkg::SET_BITS:0]   t;
                logic [fwc_pkg::SET_BITS-1:0] rem;
                rem = r_rem;
                for (int i = 0; i < fwc_pkg::MOD_STEP; i++) begin
                    t = {rem, r_val[fwc_pkg::MOD_W-1-i]};
                    if (t >= fwc_pkg::SETS_WIDE) begin
                        t = t - fwc_pkg::SETS_WIDE;
                    end
                    rem = t[fwc_pkg::SET_BITS-1:0];
                end
                n_rem = rem;
            end

            assign w_last = (r_cnt == fwc_pkg::MOD_CNT_W'(fwc_pkg::MOD_CYCLES - 1));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_run <= 1'b0;
                    r_cnt <= '0;
                end else if (i_start) begin
                    r_run <= 1'b1;
                    r_cnt <= '0;
                end else if (r_run) begin
                    r_run <= !w_last;
                    r_cnt <= r_cnt + 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= fwc_pkg::MOD_W'(i_quot);
                    r_rem <= '0;
                end else if (r_run) begin
                    r_val <= r_val << fwc_pkg::MOD_STEP;
                    r_rem <= n_rem;
                end
            end

            assign o_done = r_run && w_last;
            assign o_set  = n_rem;
        end
    endgenerate

endmodule

/* design/fwc_lookup.sv */
// ----------------------------------------------------------------------------
// fwc_lookup
// Tag compare, victim choice and updated set row for one access.
// ----------------------------------------------------------------------------
module fwc_lookup (
    input  fwc_pkg::t_set_row          i_row,
    input  logic [fwc_pkg::TAG_W-1:0]  i_tag,
    input  logic                       i_write,
    output fwc_pkg::t_lookup           o_look,
    output fwc_pkg::t_set_row          o_row
);

    always_comb begin
        logic       hit;
        logic       found;
        logic [1:0] hit_way;
        logic [1:0] free_way;
        logic [1:0] way;
        fwc_pkg::t_set_row row;

        hit      = 1'b0;
        hit_way  = 2'd0;
        found    = 1'b0;
        free_way = 2'd0;
        for (int w = fwc_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (i_row.ways[w].valid && (i_row.ways[w].tag == i_tag)) begin
                hit     = 1'b1;
                hit_way = 2'(w);
            end
            if (!i_row.ways[w].valid) begin
                found    = 1'b1;
                free_way = 2'(w);
            end
        end

        if (hit) begin
            way = hit_way;
        end else if (found) begin
            way = free_way;
        end else begin
            way = fwc_pkg::VICTIM_OF_STATE[i_row.plru];
        end

        o_look.hit        = hit;
        o_look.way        = way;
        o_look.write_back = !hit && i_row.ways[way].valid && i_row.ways[way].dirty;

        row = i_row;
        if (!hit) begin
            row.ways[way].valid = 1'b1;
            row.ways[way].dirty = 1'b0;
            row.ways[way].tag   = i_tag;
        end
        row.plru = fwc_pkg::PLRU_NEXT[i_row.plru][way];
        if (i_write) begin
            row.ways[way].dirty = 1'b1;
        end
        o_row = row;
    end

endmodule
